### rtl/mrr_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte step for the single-register read unit.
package mrr_pkg;

    // Input item operation codes
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Reading status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_FUNCTION_CODE  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'h01;
    localparam logic [7:0]  RST_FUNCTION_CODE  = 8'h04;
    localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd200;

    // Frame constants
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FRAME_ZERO    = 8'h00;
    localparam logic [7:0]  FRAME_QTY_LO  = 8'h01;
    localparam logic [7:0]  BYTE_COUNT_OK = 8'h02;
    localparam logic [3:0]  FRAME_LEN     = 4'd8;

    // Byte positions in the request frame
    localparam logic [2:0] POS_DEV    = 3'd0;
    localparam logic [2:0] POS_FC     = 3'd1;
    localparam logic [2:0] POS_REG_HI = 3'd2;
    localparam logic [2:0] POS_REG_LO = 3'd3;
    localparam logic [2:0] POS_QTY_HI = 3'd4;
    localparam logic [2:0] POS_QTY_LO = 3'd5;
    localparam logic [2:0] POS_CRC_LO = 3'd6;
    localparam logic [2:0] POS_CRC_HI = 3'd7;

    // Receive phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HUNT = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_DHI  = 3'd3;
    localparam logic [2:0] PH_DLO  = 3'd4;

    // What the protocol stage hands to the result sequencer
    typedef struct packed {
        logic        is_frame;
        logic [1:0]  status;
        logic [15:0] reading;
        logic [7:0]  dev;
        logic [7:0]  fc;
        logic [7:0]  reg_addr;
    } t_load;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/mrr_if.sv
// Valid/ready channel interfaces for request items and result items.
interface mrr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] register_address;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output register_address,
                    output rx_byte, input ready);
    modport sink   (input valid, input operation, input register_address,
                    input rx_byte, output ready);
endinterface

interface mrr_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [1:0]  status;
    logic [15:0] reading;

    modport source (output valid, output kind, output tx_byte, output last_byte,
                    output status, output reading, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last_byte,
                    input status, input reading, output ready);
endinterface

### rtl/mrr_seq.sv
// Result sequencer: holds one result or streams an 8-byte request frame, CRC built on the fly.
module mrr_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load_valid,
    input  mrr_pkg::t_load i_load,
    output logic           o_free,
    mrr_res_if.source      o_res
);
    import mrr_pkg::*;

    logic [3:0]  r_cnt;
    logic [2:0]  r_idx;
    logic        r_is_frame;
    logic [1:0]  r_status;
    logic [15:0] r_reading;
    logic [7:0]  r_dev;
    logic [7:0]  r_fc;
    logic [7:0]  r_reg;
    logic [15:0] r_crc;

    logic [7:0]  cur_byte;
    logic        out_fire;

    assign out_fire = o_res.valid && o_res.ready;
    assign o_free   = (r_cnt == 4'd0) || ((r_cnt == 4'd1) && out_fire);

    always_comb begin
        case (r_idx)
            POS_DEV:    cur_byte = r_dev;
            POS_FC:     cur_byte = r_fc;
            POS_REG_HI: cur_byte = FRAME_ZERO;
            POS_REG_LO: cur_byte = r_reg;
            POS_QTY_HI: cur_byte = FRAME_ZERO;
            POS_QTY_LO: cur_byte = FRAME_QTY_LO;
            POS_CRC_LO: cur_byte = r_crc[7:0];
            POS_CRC_HI: cur_byte = r_crc[15:8];
            default:    cur_byte = FRAME_ZERO;
        endcase
    end

    assign o_res.valid     = (r_cnt != 4'd0);
    assign o_res.kind      = r_is_frame ? KIND_TX : KIND_DONE;
    assign o_res.tx_byte   = r_is_frame ? cur_byte : 8'h00;
    assign o_res.last_byte = r_is_frame && (r_idx == POS_CRC_HI);
    assign o_res.status    = r_is_frame ? ST_OK : r_status;
    assign o_res.reading   = r_is_frame ? 16'h0000 : r_reading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 4'd0;
            r_idx      <= 3'd0;
            r_is_frame <= 1'b0;
        end else if (i_load_valid && o_free) begin
            r_cnt      <= i_load.is_frame ? FRAME_LEN : 4'd1;
            r_idx      <= 3'd0;
            r_is_frame <= i_load.is_frame;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 4'd1;
            r_idx <= r_idx + 3'd1;
        end
    end

    // Payload; CRC absorbs each header byte as it leaves, ready before the CRC bytes show
    always_ff @(posedge i_clk) begin
        if (i_load_valid && o_free) begin
            r_status  <= i_load.status;
            r_reading <= i_load.reading;
            r_dev     <= i_load.dev;
            r_fc      <= i_load.fc;
            r_reg     <= i_load.reg_addr;
            r_crc     <= CRC_INIT;
        end else if (out_fire && r_is_frame && (r_idx < POS_CRC_LO)) begin
            r_crc <= crc_update(r_crc, cur_byte);
        end
    end

endmodule

### rtl/modbus_rtu_single_register_read_unit.sv
// Modbus RTU master for reading one register: request framing, reply hunting, timeout.
// An item enters the input register, the protocol logic updates the receive phase and
// loads the result sequencer, which drives the result channel. Received bytes and ticks
// flow at one per cycle while no earlier result waits in the result sequencer. A
// request makes eight frame bytes that leave one per cycle from the result sequencer
// while the result channel is ready; the next item waits in the input register
// until the last frame byte is taken. The frame CRC is computed one byte per cycle as
// the header bytes leave. A finished reading is one result with its status; a reading
// in tenths is passed on raw.
module modbus_rtu_single_register_read_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    mrr_req_if.sink     i_req,
    mrr_res_if.source   o_res
);
    import mrr_pkg::*;

    // Configuration
    logic [7:0]  r_dev_addr;
    logic [7:0]  r_func_code;
    logic [15:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= RST_DEVICE_ADDRESS;
            r_func_code <= RST_FUNCTION_CODE;
            r_timeout   <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_dev_addr  <= i_cfg_data[7:0];
                CFG_FUNCTION_CODE:  r_func_code <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS:  r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_reg;
    logic [7:0] r_in_rx;
    logic       seq_free;
    logic       fire;

    assign fire        = r_in_valid && seq_free;
    assign i_req.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op  <= i_req.operation;
            r_in_reg <= i_req.register_address;
            r_in_rx  <= i_req.rx_byte;
        end
    end

    // Receive protocol state
    logic [2:0]  r_phase,  n_phase;
    logic        r_seen,   n_seen;
    logic [7:0]  r_hi,     n_hi;
    logic [15:0] r_quiet,  n_quiet;
    logic [16:0] quiet_inc;
    logic        load_valid;
    t_load       load;

    assign quiet_inc = {1'b0, r_quiet} + 17'd1;

    always_comb begin
        n_phase         = r_phase;
        n_seen          = r_seen;
        n_hi            = r_hi;
        n_quiet         = r_quiet;
        load_valid      = 1'b0;
        load.is_frame   = 1'b0;
        load.status     = ST_OK;
        load.reading    = 16'h0000;
        load.dev        = r_dev_addr;
        load.fc         = r_func_code;
        load.reg_addr   = r_in_reg;
        case (r_in_op)
            OP_REQUEST: begin
                load_valid    = 1'b1;
                load.is_frame = 1'b1;
                n_phase       = PH_HUNT;
                n_seen        = 1'b0;
                n_hi          = 8'h00;
                n_quiet       = 16'h0000;
            end
            OP_RX_BYTE: begin
                case (r_phase)
                    PH_HUNT: begin
                        n_quiet = 16'h0000;
                        if (r_seen && (r_in_rx == r_func_code)) begin
                            n_seen  = 1'b0;
                            n_phase = PH_COUNT;
                        end else begin
                            // a byte breaking the pair may itself start a new pair
                            n_seen = (r_in_rx == r_dev_addr);
                        end
                    end
                    PH_COUNT: begin
                        if (r_in_rx != BYTE_COUNT_OK) begin
                            n_phase     = PH_IDLE;
                            load_valid  = 1'b1;
                            load.status = ST_BAD_LEN;
                        end else begin
                            n_phase = PH_DHI;
                        end
                    end
                    PH_DHI: begin
                        n_hi    = r_in_rx;
                        n_phase = PH_DLO;
                    end
                    PH_DLO: begin
                        n_phase      = PH_IDLE;
                        load_valid   = 1'b1;
                        load.status  = ST_OK;
                        load.reading = {r_hi, r_in_rx};
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (r_phase == PH_HUNT) begin
                    // zero timeout behaves as one
                    if (quiet_inc >= {1'b0, r_timeout}) begin
                        n_phase     = PH_IDLE;
                        n_seen      = 1'b0;
                        n_quiet     = 16'h0000;
                        load_valid  = 1'b1;
                        load.status = ST_TIMEOUT;
                    end else begin
                        n_quiet = quiet_inc[15:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seen  <= 1'b0;
            r_hi    <= 8'h00;
            r_quiet <= 16'h0000;
        end else if (fire) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_hi    <= n_hi;
            r_quiet <= n_quiet;
        end
    end

    mrr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (fire && load_valid),
        .i_load       (load),
        .o_free       (seq_free),
        .o_res        (o_res)
    );

endmodule

### dv/tb.sv
// Testbench for the single-register Modbus RTU read unit: random traffic checked against a predictor.
module tb;
    import mrr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 80;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [7:0] rx;
    } line_event_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic [1:0]  status;
        logic [15:0] reading;
    } unit_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    mrr_req_if req_ch();
    mrr_res_if res_ch();

    modbus_rtu_single_register_read_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // Predictor copy of the configuration and receive state
    logic [7:0]  cfg_dev;
    logic [7:0]  cfg_fc;
    logic [15:0] cfg_timeout;
    logic [2:0]  rx_phase;
    logic        pair_half_seen;
    logic [7:0]  data_hi;
    logic [15:0] quiet_count;

    line_event_t  pending_events[$];
    unit_result_t expected_results[$];

    int n_issued = 0;
    int n_accepted = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    bit idling_on = 1'b1;
    int long_holds_asked = 0;
    int long_holds_served = 0;
    int send_gap = 0;
    int stall_gap = 0;
    int hold_left = 0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic expect_done(input logic [1:0] st, input logic [15:0] value);
        unit_result_t r;
        r.kind = KIND_DONE;
        r.tx = 8'h00;
        r.last = 1'b0;
        r.status = st;
        r.reading = value;
        expected_results.push_back(r);
    endtask

    task automatic predict_line_event(input line_event_t ev);
        logic [7:0]   frame [8];
        logic [15:0]  crc;
        logic [16:0]  next_quiet;
        unit_result_t r;
        case (ev.op)
            OP_REQUEST: begin
                frame[0] = cfg_dev;
                frame[1] = cfg_fc;
                frame[2] = FRAME_ZERO;
                frame[3] = ev.reg_addr;
                frame[4] = FRAME_ZERO;
                frame[5] = FRAME_QTY_LO;
                crc = CRC_INIT;
                for (int i = 0; i < 6; i++) crc = modbus_crc_step(crc, frame[i]);
                frame[6] = crc[7:0];
                frame[7] = crc[15:8];
                for (int i = 0; i < 8; i++) begin
                    r.kind = KIND_TX;
                    r.tx = frame[i];
                    r.last = (i == 7);
                    r.status = ST_OK;
                    r.reading = 16'h0000;
                    expected_results.push_back(r);
                end
                rx_phase = PH_HUNT;
                pair_half_seen = 1'b0;
                data_hi = 8'h00;
                quiet_count = 16'h0000;
            end
            OP_RX_BYTE: begin
                case (rx_phase)
                    PH_HUNT: begin
                        quiet_count = 16'h0000;
                        if (pair_half_seen && ev.rx == cfg_fc) begin
                            pair_half_seen = 1'b0;
                            rx_phase = PH_COUNT;
                        end else begin
                            // a byte that breaks the pair may itself start a new one
                            pair_half_seen = (ev.rx == cfg_dev);
                        end
                    end
                    PH_COUNT: begin
                        if (ev.rx != BYTE_COUNT_OK) begin
                            rx_phase = PH_IDLE;
                            expect_done(ST_BAD_LEN, 16'h0000);
                        end else begin
                            rx_phase = PH_DHI;
                        end
                    end
                    PH_DHI: begin
                        data_hi = ev.rx;
                        rx_phase = PH_DLO;
                    end
                    PH_DLO: begin
                        rx_phase = PH_IDLE;
                        expect_done(ST_OK, {data_hi, ev.rx});
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (rx_phase == PH_HUNT) begin
                    next_quiet = {1'b0, quiet_count} + 17'd1;
                    if (next_quiet >= {1'b0, cfg_timeout}) begin
                        rx_phase = PH_IDLE;
                        pair_half_seen = 1'b0;
                        quiet_count = 16'h0000;
                        expect_done(ST_TIMEOUT, 16'h0000);
                    end else begin
                        quiet_count = next_quiet[15:0];
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Input driver: holds an item until its transaction completes
    always @(negedge i_clk) begin
        line_event_t ev;
        if (req_ch.valid && n_accepted != n_issued) begin
            // still waiting for ready
        end else if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
        end else if (pending_events.size() == 0) begin
            req_ch.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            send_gap = $urandom_range(0, 2);
        end else begin
            ev = pending_events.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.operation <= ev.op;
            req_ch.register_address <= ev.reg_addr;
            req_ch.rx_byte <= ev.rx;
            n_issued++;
        end
    end

    // Result-side ready: random short stalls plus an occasional long hold
    always @(negedge i_clk) begin
        if (long_holds_served != long_holds_asked) begin
            hold_left = LONG_HOLD;
            long_holds_served++;
        end
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (stall_gap > 0) begin
            res_ch.ready <= 1'b0;
            stall_gap--;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            res_ch.ready <= 1'b0;
            stall_gap = $urandom_range(0, 2);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Monitor: predicts on input transactions, checks result transactions
    always @(posedge i_clk) begin
        line_event_t  ev;
        unit_result_t exp_r;
        bit           moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (req_ch.valid && req_ch.ready) begin
                ev.op = req_ch.operation;
                ev.reg_addr = req_ch.register_address;
                ev.rx = req_ch.rx_byte;
                predict_line_event(ev);
                n_accepted++;
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: kind %0d tx %0h status %0d",
                           res_ch.kind, res_ch.tx_byte, res_ch.status);
                    mismatches++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("kind", 16'(exp_r.kind), 16'(res_ch.kind));
                    check_field("tx_byte", 16'(exp_r.tx), 16'(res_ch.tx_byte));
                    check_field("last_byte", 16'(exp_r.last), 16'(res_ch.last_byte));
                    check_field("status", 16'(exp_r.status), 16'(res_ch.status));
                    check_field("reading", exp_r.reading, res_ch.reading);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_event(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] rb);
        line_event_t ev;
        ev.op = op;
        ev.reg_addr = ra;
        ev.rx = rb;
        pending_events.push_back(ev);
    endtask

    task automatic push_rx(input logic [7:0] b);
        push_event(OP_RX_BYTE, 8'($urandom_range(0, 255)), b);
        if ($urandom_range(0, 7) == 0) push_event(OP_TICK, 8'($urandom_range(0, 255)),
                                                  8'($urandom_range(0, 255)));
    endtask

    task automatic queue_reply(input logic [7:0] count_byte);
        push_rx(cfg_dev);
        push_rx(cfg_fc);
        push_rx(count_byte);
        push_rx(8'($urandom_range(0, 255)));
        push_rx(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_random_exchanges(input int n_items);
        int start;
        int sel;
        int n;
        logic [7:0] partial [4];
        start = pending_events.size();
        while (pending_events.size() - start < n_items) begin
            sel = $urandom_range(0, 9);
            if (sel != 9) push_event(OP_REQUEST, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            case (sel)
                0, 1, 2, 3, 4: begin
                    // line noise ahead of a good reply
                    repeat ($urandom_range(0, 2)) push_rx(8'($urandom_range(0, 255)));
                    queue_reply(BYTE_COUNT_OK);
                end
                5: queue_reply(8'($urandom_range(0, 255)));
                6: begin
                    n = (cfg_timeout == 16'd0) ? 1 :
                        (cfg_timeout <= 16'd12) ? int'(cfg_timeout) : 3;
                    repeat (n) push_event(OP_TICK, 8'($urandom_range(0, 255)),
                                          8'($urandom_range(0, 255)));
                end
                7: begin
                    // reply cut short; the next request abandons it
                    partial[0] = cfg_dev;
                    partial[1] = cfg_fc;
                    partial[2] = BYTE_COUNT_OK;
                    partial[3] = 8'($urandom_range(0, 255));
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) push_rx(partial[i]);
                end
                8: begin
                    push_rx(cfg_dev);
                    push_rx(8'($urandom_range(0, 255)));
                    queue_reply(BYTE_COUNT_OK);
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        push_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_DEVICE_ADDRESS: cfg_dev = value[7:0];
            CFG_FUNCTION_CODE:  cfg_fc = value[7:0];
            CFG_TIMEOUT_TICKS:  cfg_timeout = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [7:0] dev, input logic [7:0] fc, input logic [15:0] to);
        set_register(CFG_DEVICE_ADDRESS, {8'h00, dev});
        set_register(CFG_FUNCTION_CODE, {8'h00, fc});
        set_register(CFG_TIMEOUT_TICKS, to);
    endtask

    task automatic wait_until_drained();
        while (pending_events.size() != 0 || n_accepted != n_issued ||
               expected_results.size() != 0)
            @(posedge i_clk);
        // a trailing byte or tick may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DEVICE_ADDRESS;
        i_cfg_data = 16'h0000;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_REQUEST;
        req_ch.register_address = 8'h00;
        req_ch.rx_byte = 8'h00;
        res_ch.ready = 1'b0;
        cfg_dev = RST_DEVICE_ADDRESS;
        cfg_fc = RST_FUNCTION_CODE;
        cfg_timeout = RST_TIMEOUT_TICKS;
        rx_phase = PH_IDLE;
        pair_half_seen = 1'b0;
        data_hi = 8'h00;
        quiet_count = 16'h0000;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset configuration
        push_event(OP_RX_BYTE, 8'h00, 8'h01);   // byte while idle
        push_event(OP_TICK, 8'hFF, 8'hFF);      // tick while idle
        push_event(OP_UNUSED, 8'hFF, 8'hFF);
        push_event(OP_REQUEST, 8'h00, 8'h00);
        push_event(OP_RX_BYTE, 8'h00, 8'h01);
        push_event(OP_RX_BYTE, 8'h00, 8'h04);
        push_event(OP_RX_BYTE, 8'h00, 8'h02);
        push_event(OP_RX_BYTE, 8'h00, 8'hFF);
        push_event(OP_RX_BYTE, 8'h00, 8'hFF);
        push_event(OP_REQUEST, 8'hFF, 8'h00);
        push_event(OP_RX_BYTE, 8'h00, 8'h07);
        push_event(OP_RX_BYTE, 8'h00, 8'h01);
        push_event(OP_RX_BYTE, 8'h00, 8'h01);   // repeated address rechecked
        push_event(OP_RX_BYTE, 8'h00, 8'h04);
        push_event(OP_TICK, 8'h00, 8'h00);      // ignored while waiting for the count
        push_event(OP_RX_BYTE, 8'h00, 8'h05);   // bad byte count
        push_event(OP_REQUEST, 8'h5A, 8'h00);
        push_event(OP_RX_BYTE, 8'h00, 8'h01);
        push_event(OP_RX_BYTE, 8'h00, 8'h04);
        push_event(OP_RX_BYTE, 8'h00, 8'h02);
        push_event(OP_REQUEST, 8'hA5, 8'h00);   // abandons the pending reply
        queue_reply(BYTE_COUNT_OK);
        wait_until_drained();

        // Low extremes; zero timeout fires on the first quiet tick
        set_all(8'h00, 8'h00, 16'h0000);
        push_event(OP_REQUEST, 8'h33, 8'h00);
        push_event(OP_TICK, 8'h00, 8'h00);
        queue_random_exchanges(75);
        wait_until_drained();

        // High extremes, with a long result-side hold while input keeps coming
        set_all(8'hFF, 8'hFF, 16'hFFFF);
        queue_random_exchanges(75);
        long_holds_asked++;
        wait_until_drained();

        set_all(8'($urandom_range(0, 255)), 8'h03, 16'($urandom_range(1, 6)));
        queue_random_exchanges(75);
        wait_until_drained();

        idling_on = 1'b0;
        set_all(8'($urandom_range(0, 255)), RST_FUNCTION_CODE, 16'($urandom_range(7, 12)));
        queue_random_exchanges(75);
        wait_until_drained();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
